// File: hw/rtl/gcs_pkg.sv
// shared types, constants and helpers for the golomb coded set decoder
`timescale 1ns / 1ps
`default_nettype none

package gcs_pkg;

  localparam int DATA_W   = 8;
  localparam int DIV_W    = 16;
  localparam int MEMBER_W = 32;
  localparam int DELTA_W  = 32;
  localparam int LEFT_W   = 5;
  localparam int CNT_W    = 3;

  localparam logic [DIV_W-1:0] DIVISOR_RESET = 16'd50;

  // top level sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BITS,
    ST_CLOSE,
    ST_FLUSH
  } state_t;

  // one result word before the run end flag is known
  typedef struct packed {
    logic [MEMBER_W-1:0] member;
    logic                member_valid;
    logic                set_done;
  } res_t;

  // sequencer to bit engine
  typedef struct packed {
    logic load;
    logic step;
    logic close;
  } eng_ctrl_t;

  // bit engine to sequencer
  typedef struct packed {
    logic produce;
  } eng_stat_t;

  // sequencer to output stage
  typedef struct packed {
    logic push;
    logic flush;
  } ostage_ctrl_t;

  // output stage to sequencer
  typedef struct packed {
    logic hold_valid;
    logic out_free;
    logic blocked;
  } ostage_stat_t;

  // remainder width: bits needed to hold divisor-1
  function automatic logic [LEFT_W-1:0] rem_width(input logic [DIV_W-1:0] divisor);
    logic [DIV_W-1:0]  v;
    logic [LEFT_W-1:0] n;
    v = divisor - DIV_W'(1);
    n = '0;
    for (int i = 0; i < DIV_W; i++) begin
      if (v[i]) begin
        n = LEFT_W'(i + 1);
      end
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/gcs_bit_engine.sv
// bit serial golomb code engine: byte shift register, delta and running sum
`timescale 1ns / 1ps
`default_nettype none

module gcs_bit_engine #(
  parameter int SUM_WIDTH = 32
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         cfg_we,
  input  wire  [gcs_pkg::DIV_W-1:0]   cfg_wdata,
  input  wire  [gcs_pkg::DATA_W-1:0]  load_byte,
  input  gcs_pkg::eng_ctrl_t          ctrl,
  output gcs_pkg::eng_stat_t          stat,
  output logic [SUM_WIDTH-1:0]        sum_out
);

  logic [gcs_pkg::DIV_W-1:0]   divisor_r;
  logic [gcs_pkg::LEFT_W-1:0]  rem_w_r;
  logic [gcs_pkg::DATA_W-1:0]  sh_r, sh_nxt;
  logic                        in_rem_r, in_rem_nxt;
  logic [gcs_pkg::DELTA_W-1:0] partial_r, partial_nxt;
  logic [gcs_pkg::LEFT_W-1:0]  left_r, left_nxt;
  logic [gcs_pkg::DIV_W-1:0]   rem_r, rem_nxt;
  logic [SUM_WIDTH-1:0]        prev_r, prev_nxt;
  logic [SUM_WIDTH-1:0]        base_r, base_nxt;

  logic                        cur_bit;
  logic                        finish;
  logic [SUM_WIDTH-1:0]        sum_new;

  // divisor register and its remainder width
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      divisor_r <= gcs_pkg::DIVISOR_RESET;
      rem_w_r   <= gcs_pkg::rem_width(gcs_pkg::DIVISOR_RESET);
    end else if (cfg_we) begin
      divisor_r <= cfg_wdata;
      rem_w_r   <= gcs_pkg::rem_width(cfg_wdata);
    end
  end

  // decode of the bit at the head of the shift register
  always_comb begin
    cur_bit     = sh_r[gcs_pkg::DATA_W-1];
    in_rem_nxt  = in_rem_r;
    partial_nxt = partial_r;
    left_nxt    = left_r;
    rem_nxt     = rem_r;
    base_nxt    = base_r;
    finish      = 1'b0;
    sum_new     = prev_r;
    if (!in_rem_r) begin
      if (cur_bit) begin
        // unary one adds the divisor
        partial_nxt = partial_r + gcs_pkg::DELTA_W'(divisor_r);
      end else begin
        // quotient ends, fold it into the sum base
        base_nxt = prev_r + partial_r[SUM_WIDTH-1:0];
        rem_nxt  = '0;
        if (rem_w_r == '0) begin
          finish  = 1'b1;
          sum_new = base_nxt;
        end else begin
          in_rem_nxt = 1'b1;
          left_nxt   = rem_w_r;
        end
      end
    end else begin
      // remainder bits shift in msb first
      rem_nxt  = {rem_r[gcs_pkg::DIV_W-2:0], cur_bit};
      left_nxt = left_r - gcs_pkg::LEFT_W'(1);
      if (left_r == gcs_pkg::LEFT_W'(1)) begin
        finish  = 1'b1;
        sum_new = base_r + SUM_WIDTH'(rem_nxt);
      end
    end
    if (finish) begin
      in_rem_nxt  = 1'b0;
      partial_nxt = '0;
      left_nxt    = '0;
      rem_nxt     = '0;
    end
    // a zero delta leaves the sum unchanged and emits nothing
    stat.produce = finish && (sum_new != prev_r);
    prev_nxt     = sum_new;
    sum_out      = sum_new;
  end

  // byte shift register and delta base
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      sh_r <= load_byte;
    end else if (ctrl.step) begin
      sh_r <= sh_nxt;
    end
    if (ctrl.step) begin
      base_r <= base_nxt;
    end
  end

  assign sh_nxt = {sh_r[gcs_pkg::DATA_W-2:0], 1'b0};

  // code state and running sum
  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.close) begin
      in_rem_r  <= 1'b0;
      partial_r <= '0;
      left_r    <= '0;
      rem_r     <= '0;
      prev_r    <= '0;
    end else if (ctrl.step) begin
      in_rem_r  <= in_rem_nxt;
      partial_r <= partial_nxt;
      left_r    <= left_nxt;
      rem_r     <= rem_nxt;
      prev_r    <= prev_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/gcs_out_stage.sv
// result hold register and output register with run end marking
`timescale 1ns / 1ps
`default_nettype none

module gcs_out_stage (
  input  wire                  clk,
  input  wire                  rst_n,
  input  gcs_pkg::ostage_ctrl_t ctrl,
  input  gcs_pkg::res_t        res_in,
  output gcs_pkg::ostage_stat_t stat,
  output logic                 out_tvalid,
  input  wire                  out_tready,
  output gcs_pkg::res_t        out_res,
  output logic                 out_run_end
);

  gcs_pkg::res_t hold_r, hold_nxt;
  logic          hold_v_r, hold_v_nxt;
  gcs_pkg::res_t out_r, out_nxt;
  logic          out_v_r, out_v_nxt;
  logic          out_end_r, out_end_nxt;
  logic          out_free;

  // a new word pushes the held one out; the held word leaves last on flush
  always_comb begin
    out_free    = !out_v_r || out_tready;
    hold_nxt    = hold_r;
    hold_v_nxt  = hold_v_r;
    out_nxt     = out_r;
    out_end_nxt = out_end_r;
    out_v_nxt   = out_v_r && !out_tready;
    if (ctrl.push) begin
      if (hold_v_r) begin
        out_nxt     = hold_r;
        out_end_nxt = 1'b0;
        out_v_nxt   = 1'b1;
      end
      hold_nxt   = res_in;
      hold_v_nxt = 1'b1;
    end else if (ctrl.flush && hold_v_r && out_free) begin
      out_nxt     = hold_r;
      out_end_nxt = 1'b1;
      out_v_nxt   = 1'b1;
      hold_v_nxt  = 1'b0;
    end
    stat.hold_valid = hold_v_r;
    stat.out_free   = out_free;
    stat.blocked    = hold_v_r && !out_free;
  end

  // payload registers
  always_ff @(posedge clk) begin
    hold_r    <= hold_nxt;
    out_r     <= out_nxt;
    out_end_r <= out_end_nxt;
  end

  // valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      hold_v_r <= hold_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  assign out_tvalid  = out_v_r;
  assign out_res     = out_r;
  assign out_run_end = out_end_r;

endmodule

`default_nettype wire

// File: hw/rtl/golomb_set_stream_decoder_top.sv
// top level of the golomb coded set stream decoder: sequencer and assertions
//
//  channel | direction | tdata                | tuser                     | tlast
//  in_     | in        | [7:0] data_byte      | -                         | last_byte
//  out_    | out       | [31:0] member        | [0] member_valid [1] set_done | run_end
//  cfg_    | in        | cfg_wdata [15:0] divisor, written when cfg_we is high
//
// per byte: the idle state takes the word, the bits state shifts its bits through the
// bit engine one per cycle unless stalled, the close state issues the closing word if
// the byte closes the set, and the flush state releases the held result word.
// reset is synchronous and active low; it restores the divisor to 50 and clears
// the running sum. a stalled output holds the engine only when a new member is due.
`timescale 1ns / 1ps
`default_nettype none

module golomb_set_stream_decoder_top #(
  parameter int SUM_WIDTH = 32
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         cfg_we,
  input  wire  [15:0] cfg_wdata,    // divisor
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [7:0]  in_tdata,     // [7:0] data_byte
  input  wire         in_tlast,     // last_byte
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [31:0] out_tdata,    // [31:0] member
  output logic [1:0]  out_tuser,    // [0] member_valid, [1] set_done
  output logic        out_tlast     // run_end
);

  localparam logic [gcs_pkg::CNT_W-1:0] CNT_LAST = gcs_pkg::CNT_W'(gcs_pkg::DATA_W - 1);

  gcs_pkg::state_t       state_r, state_nxt;
  logic [gcs_pkg::CNT_W-1:0] cnt_r;
  logic                  last_r;
  gcs_pkg::eng_ctrl_t    eng_ctrl;
  gcs_pkg::eng_stat_t    eng_stat;
  gcs_pkg::ostage_ctrl_t os_ctrl;
  gcs_pkg::ostage_stat_t os_stat;
  gcs_pkg::res_t         push_res;
  gcs_pkg::res_t         out_res;
  logic [SUM_WIDTH-1:0]  eng_sum;
  logic                  step_ok;

  gcs_bit_engine #(
    .SUM_WIDTH (SUM_WIDTH)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .load_byte (in_tdata),
    .ctrl      (eng_ctrl),
    .stat      (eng_stat),
    .sum_out   (eng_sum)
  );

  gcs_out_stage u_out (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctrl        (os_ctrl),
    .res_in      (push_res),
    .stat        (os_stat),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_res     (out_res),
    .out_run_end (out_tlast)
  );

  assign step_ok = !(eng_stat.produce && os_stat.blocked);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gcs_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = gcs_pkg::ST_BITS;
        end
      end
      gcs_pkg::ST_BITS: begin
        if (step_ok && cnt_r == CNT_LAST) begin
          state_nxt = last_r ? gcs_pkg::ST_CLOSE : gcs_pkg::ST_FLUSH;
        end
      end
      gcs_pkg::ST_CLOSE: begin
        if (!os_stat.blocked) begin
          state_nxt = gcs_pkg::ST_FLUSH;
        end
      end
      gcs_pkg::ST_FLUSH: begin
        if (!os_stat.hold_valid || os_stat.out_free) begin
          state_nxt = gcs_pkg::ST_IDLE;
        end
      end
      default: state_nxt = gcs_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_tready     = 1'b0;
    eng_ctrl      = '0;
    os_ctrl       = '0;
    push_res.member       = gcs_pkg::MEMBER_W'(eng_sum);
    push_res.member_valid = 1'b1;
    push_res.set_done     = 1'b0;
    case (state_r)
      gcs_pkg::ST_IDLE: begin
        in_tready     = 1'b1;
        eng_ctrl.load = in_tvalid;
      end
      gcs_pkg::ST_BITS: begin
        eng_ctrl.step = step_ok;
        os_ctrl.push  = step_ok && eng_stat.produce;
      end
      gcs_pkg::ST_CLOSE: begin
        eng_ctrl.close        = !os_stat.blocked;
        os_ctrl.push          = !os_stat.blocked;
        push_res.member       = '0;
        push_res.member_valid = 1'b0;
        push_res.set_done     = 1'b1;
      end
      gcs_pkg::ST_FLUSH: begin
        os_ctrl.flush = 1'b1;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  // state, bit count and last flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gcs_pkg::ST_IDLE;
      cnt_r   <= '0;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (eng_ctrl.load) begin
        cnt_r  <= '0;
        last_r <= in_tlast;
      end else if (eng_ctrl.step) begin
        cnt_r <= cnt_r + gcs_pkg::CNT_W'(1);
      end
    end
  end

  assign out_tdata = out_res.member;
  assign out_tuser = {out_res.set_done, out_res.member_valid};

  // a held member must be gone before the next byte comes in
  a_hold_empty_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |-> !os_stat.hold_valid)
    else $error("held result still pending at byte accept");

  // the engine never finishes a member into a full output path
  a_no_step_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    eng_ctrl.step && eng_stat.produce |-> !os_stat.blocked)
    else $error("member produced while output path full");

  // a closing word carries no member and ends its run
  a_close_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tdata == 32'd0 && !out_tuser[0] && out_tlast)
    else $error("malformed closing word");

  // a closing word is issued only for a byte marked last
  a_close_needs_last: assert property (@(posedge clk) disable iff (!rst_n)
    eng_ctrl.close |-> last_r)
    else $error("set closed without a last byte");

endmodule

`default_nettype wire

// File: dv/tb.sv
// testbench for the golomb coded set stream decoder: directed table, random sets, scoreboard
`timescale 1ns / 1ps

module tb;

  // one result word as seen on the out_ channel
  typedef struct packed {
    logic [gcs_pkg::MEMBER_W-1:0] member;
    logic                         member_valid;
    logic                         set_done;
    logic                         run_end;
  } member_word_t;

  // one row of the directed table; typed < 0 means the decoder model supplies the words
  typedef struct {
    int                         div;
    logic [gcs_pkg::DATA_W-1:0] data;
    logic                       last;
    int                         typed;
    member_word_t               word;
  } byte_row_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         cfg_we = 1'b0;
  logic [gcs_pkg::DIV_W-1:0]    cfg_wdata = '0;
  logic                         in_tvalid = 1'b0;
  logic                         in_tready;
  logic [gcs_pkg::DATA_W-1:0]   in_tdata = '0;
  logic                         in_tlast = 1'b0;
  logic                         out_tvalid;
  logic                         out_tready = 1'b0;
  logic [gcs_pkg::MEMBER_W-1:0] out_tdata;
  logic [1:0]                   out_tuser;
  logic                         out_tlast;

  // decoder model state
  logic [gcs_pkg::DIV_W-1:0]    div_reg = gcs_pkg::DIVISOR_RESET;
  logic                         in_rem = 1'b0;
  logic [gcs_pkg::DELTA_W-1:0]  part_delta = '0;
  logic [gcs_pkg::LEFT_W-1:0]   rem_left = '0;
  logic [gcs_pkg::DIV_W-1:0]    rem_bits = '0;
  logic [gcs_pkg::MEMBER_W-1:0] run_sum = '0;

  member_word_t decoded_words[$];
  member_word_t expected_members[$];
  byte_row_t    dir_rows[$];
  member_word_t want;

  int err_count = 0;
  int send_idle_pct = 9;
  int recv_idle_pct = 73;
  int rand_items = 0;

  golomb_set_stream_decoder_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  // clock
  initial begin
    forever #10 clk = ~clk;
  end

  // run limit
  initial begin
    #30_000_000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic member_word_t make_word(input logic [gcs_pkg::MEMBER_W-1:0] m,
                                             input logic mv, input logic sd,
                                             input logic re);
    member_word_t w;
    w.member       = m;
    w.member_valid = mv;
    w.set_done     = sd;
    w.run_end      = re;
    return w;
  endfunction

  // number of bits that hold divisor-1
  function automatic int rem_width_of(input logic [gcs_pkg::DIV_W-1:0] d);
    logic [gcs_pkg::DIV_W-1:0] v;
    int n;
    v = d - gcs_pkg::DIV_W'(1);
    n = 0;
    while (v != '0) begin
      n++;
      v = v >> 1;
    end
    return n;
  endfunction

  // a finished code adds its delta to the running sum; zero deltas emit nothing
  function automatic void close_code();
    logic [gcs_pkg::DELTA_W-1:0] delta;
    delta = part_delta + {{(gcs_pkg::DELTA_W-gcs_pkg::DIV_W){1'b0}}, rem_bits};
    in_rem     = 1'b0;
    part_delta = '0;
    rem_left   = '0;
    rem_bits   = '0;
    if (delta != '0) begin
      run_sum = run_sum + delta;
      decoded_words.push_back(make_word(run_sum, 1'b1, 1'b0, 1'b0));
    end
  endfunction

  // decode one byte msb first into decoded_words
  function automatic void decode_byte(input logic [gcs_pkg::DATA_W-1:0] b, input logic l);
    member_word_t tail;
    decoded_words.delete();
    for (int i = gcs_pkg::DATA_W - 1; i >= 0; i--) begin
      if (!in_rem) begin
        if (b[i]) begin
          part_delta = part_delta + {{(gcs_pkg::DELTA_W-gcs_pkg::DIV_W){1'b0}}, div_reg};
        end else begin
          in_rem   = 1'b1;
          rem_bits = '0;
          rem_left = gcs_pkg::LEFT_W'(rem_width_of(div_reg));
          if (rem_left == '0) close_code();
        end
      end else begin
        rem_bits = {rem_bits[gcs_pkg::DIV_W-2:0], b[i]};
        rem_left = rem_left - gcs_pkg::LEFT_W'(1);
        if (rem_left == '0) close_code();
      end
    end
    // last byte drops any pending code and closes the set
    if (l) begin
      in_rem     = 1'b0;
      part_delta = '0;
      rem_left   = '0;
      rem_bits   = '0;
      run_sum    = '0;
      decoded_words.push_back(make_word('0, 1'b0, 1'b1, 1'b0));
    end
    if (decoded_words.size() > 0) begin
      tail = decoded_words.pop_back();
      tail.run_end = 1'b1;
      decoded_words.push_back(tail);
    end
  endfunction

  function automatic void add_row(input int div, input logic [gcs_pkg::DATA_W-1:0] data,
                                  input logic last, input int typed,
                                  input logic [gcs_pkg::MEMBER_W-1:0] m, input logic mv,
                                  input logic sd, input logic re);
    byte_row_t r;
    r.div   = div;
    r.data  = data;
    r.last  = last;
    r.typed = typed;
    r.word  = make_word(m, mv, sd, re);
    dir_rows.push_back(r);
  endfunction

  // send one word on in_, then book what it should produce
  task automatic push_byte(input logic [gcs_pkg::DATA_W-1:0] b, input logic l,
                           input int typed, input member_word_t w);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= l;
    do @(posedge clk); while (!in_tready);
    decode_byte(b, l);
    if (typed < 0) begin
      for (int i = 0; i < decoded_words.size(); i++) expected_members.push_back(decoded_words[i]);
    end else if (typed > 0) begin
      expected_members.push_back(w);
    end
  endtask

  // hold the sender until every expected word is out and the block is quiet
  task automatic drain();
    in_tvalid <= 1'b0;
    while (expected_members.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic set_divisor(input logic [gcs_pkg::DIV_W-1:0] v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    div_reg = v;
  endtask

  // one coded set: mostly well formed codes, some truncated, some plain noise
  task automatic send_random_set();
    bit code_bits[$];
    int w;
    int ncodes;
    int q;
    int cut;
    int nbytes;
    logic [gcs_pkg::DIV_W-1:0]  r;
    logic [gcs_pkg::DATA_W-1:0] b;
    logic l;
    if ($urandom_range(0, 99) < 80) begin
      w = rem_width_of(div_reg);
      ncodes = $urandom_range(1, 6);
      for (int c = 0; c < ncodes; c++) begin
        q = $urandom_range(0, (div_reg == 1) ? 6 : 3);
        for (int k = 0; k < q; k++) code_bits.push_back(1'b1);
        code_bits.push_back(1'b0);
        r = gcs_pkg::DIV_W'($urandom_range(0, (1 << w) - 1));
        for (int k = w - 1; k >= 0; k--) code_bits.push_back(r[k]);
      end
      // broken set: cut inside a code
      if ($urandom_range(0, 99) < 10 && code_bits.size() > 1) begin
        cut = $urandom_range(1, code_bits.size() - 1);
        while (code_bits.size() > cut) void'(code_bits.pop_back());
      end
      while (code_bits.size() % gcs_pkg::DATA_W != 0) begin
        code_bits.push_back(1'($urandom_range(0, 1)));
      end
      nbytes = code_bits.size() / gcs_pkg::DATA_W;
      for (int j = 0; j < nbytes; j++) begin
        for (int k = 0; k < gcs_pkg::DATA_W; k++) begin
          b[gcs_pkg::DATA_W-1-k] = code_bits[j*gcs_pkg::DATA_W+k];
        end
        l = (j == nbytes - 1) && ($urandom_range(0, 99) < 90);
        push_byte(b, l, -1, '0);
        rand_items++;
      end
    end else begin
      nbytes = $urandom_range(1, 4);
      for (int j = 0; j < nbytes; j++) begin
        push_byte(gcs_pkg::DATA_W'($urandom_range(0, 255)), $urandom_range(0, 99) < 20, -1, '0);
        rand_items++;
      end
    end
  endtask

  function automatic logic [gcs_pkg::DIV_W-1:0] pick_divisor();
    case ($urandom_range(0, 7))
      0: return gcs_pkg::DIV_W'(1);
      1: return gcs_pkg::DIV_W'(2);
      2: return gcs_pkg::DIV_W'(3);
      3: return gcs_pkg::DIVISOR_RESET;
      4: return 16'hFFFF;
      5: return '0;
      6: return gcs_pkg::DIV_W'($urandom_range(1, 65535));
      default: return gcs_pkg::DIV_W'($urandom_range(4, 300));
    endcase
  endfunction

  // receiver stalls
  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // compare each accepted result word with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_tvalid === 1'b1 && out_tready) begin
      if (expected_members.size() == 0) begin
        $error("unexpected result word: member %0h tuser %0b tlast %0b",
               out_tdata, out_tuser, out_tlast);
        err_count++;
      end else begin
        want = expected_members.pop_front();
        if (out_tdata !== want.member) begin
          $error("member: expected %0h, got %0h", want.member, out_tdata);
          err_count++;
        end
        if (out_tuser[0] !== want.member_valid) begin
          $error("member_valid: expected %0b, got %0b", want.member_valid, out_tuser[0]);
          err_count++;
        end
        if (out_tuser[1] !== want.set_done) begin
          $error("set_done: expected %0b, got %0b", want.set_done, out_tuser[1]);
          err_count++;
        end
        if (out_tlast !== want.run_end) begin
          $error("run_end: expected %0b, got %0b", want.run_end, out_tlast);
          err_count++;
        end
      end
    end
  end

  // stimulus
  initial begin
    // divisor 50 after reset
    add_row(-1, 8'h00, 1'b1,  1, 0, 1'b0, 1'b1, 1'b1);
    add_row(-1, 8'h02, 1'b0,  1, 1, 1'b1, 1'b0, 1'b1);
    add_row(-1, 8'hFF, 1'b0, -1, 0, 1'b0, 1'b0, 1'b0);
    add_row(-1, 8'h7F, 1'b0, -1, 0, 1'b0, 1'b0, 1'b0);
    add_row(-1, 8'h80, 1'b1, -1, 0, 1'b0, 1'b0, 1'b0);
    // divisor one: empty remainder, a lone zero-bit is a zero delta
    add_row(1, 8'h00, 1'b0,  0, 0, 1'b0, 1'b0, 1'b0);
    add_row(-1, 8'hAA, 1'b0, -1, 0, 1'b0, 1'b0, 1'b0);
    add_row(-1, 8'hFF, 1'b0, -1, 0, 1'b0, 1'b0, 1'b0);
    add_row(-1, 8'h01, 1'b1, -1, 0, 1'b0, 1'b0, 1'b0);
    // widest divisor, 16 bit remainder spread over bytes
    add_row(65535, 8'h80, 1'b0, 0, 0, 1'b0, 1'b0, 1'b0);
    add_row(-1, 8'hFF, 1'b0,  0, 0, 1'b0, 1'b0, 1'b0);
    add_row(-1, 8'hFF, 1'b0, -1, 0, 1'b0, 1'b0, 1'b0);
    add_row(-1, 8'h00, 1'b1, -1, 0, 1'b0, 1'b0, 1'b0);
    add_row(-1, 8'hFF, 1'b1,  1, 0, 1'b0, 1'b1, 1'b1);
    // divisor zero: ones add nothing, remainder is 16 bits
    add_row(0, 8'hFF, 1'b0,  0, 0, 1'b0, 1'b0, 1'b0);
    add_row(-1, 8'h00, 1'b0,  0, 0, 1'b0, 1'b0, 1'b0);
    add_row(-1, 8'h00, 1'b0,  0, 0, 1'b0, 1'b0, 1'b0);
    add_row(-1, 8'h80, 1'b0,  1, 1, 1'b1, 1'b0, 1'b1);
    add_row(-1, 8'h55, 1'b1, -1, 0, 1'b0, 1'b0, 1'b0);
    // small divisors, remainder may exceed divisor-1
    add_row(2, 8'h55, 1'b0, -1, 0, 1'b0, 1'b0, 1'b0);
    add_row(-1, 8'hC0, 1'b1, -1, 0, 1'b0, 1'b0, 1'b0);
    add_row(3, 8'h3F, 1'b0, -1, 0, 1'b0, 1'b0, 1'b0);
    add_row(-1, 8'hFF, 1'b1, -1, 0, 1'b0, 1'b0, 1'b0);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < dir_rows.size(); i++) begin
      if (dir_rows[i].div >= 0) set_divisor(gcs_pkg::DIV_W'(dir_rows[i].div));
      push_byte(dir_rows[i].data, dir_rows[i].last, dir_rows[i].typed, dir_rows[i].word);
    end

    // random sets across divisors and idle patterns
    while (dir_rows.size() + rand_items < 310) begin
      if (rand_items < 96) begin
        send_idle_pct = 9;
        recv_idle_pct = 73;
      end else if (rand_items < 192) begin
        send_idle_pct = 73;
        recv_idle_pct = 9;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if ($urandom_range(0, 99) < 25) begin
        set_divisor(pick_divisor());
      end else if ($urandom_range(0, 99) < 5) begin
        drain();
      end
      send_random_set();
    end

    drain();
    repeat (8) @(posedge clk);
    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: golomb_set_stream_decoder_top.f
hw/rtl/gcs_pkg.sv
hw/rtl/gcs_bit_engine.sv
hw/rtl/gcs_out_stage.sv
hw/rtl/golomb_set_stream_decoder_top.sv
dv/tb.sv
